// ===== sv/mp3sip_pkg.sv =====
// Shared types, step codes and field tables of the Layer III side-info parser.
package mp3sip_pkg;

  localparam int unsigned MAIN_BYTES_MAX = 2047;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] ST_MDB    = 5'd1;
  localparam logic [STEP_W-1:0] ST_PRIV   = 5'd2;
  localparam logic [STEP_W-1:0] ST_SCFSI  = 5'd3;
  localparam logic [STEP_W-1:0] ST_P23    = 5'd4;
  localparam logic [STEP_W-1:0] ST_BIGV   = 5'd5;
  localparam logic [STEP_W-1:0] ST_GGAIN  = 5'd6;
  localparam logic [STEP_W-1:0] ST_SFC    = 5'd7;
  localparam logic [STEP_W-1:0] ST_WS     = 5'd8;
  localparam logic [STEP_W-1:0] ST_BTYPE  = 5'd9;
  localparam logic [STEP_W-1:0] ST_MIXED  = 5'd10;
  localparam logic [STEP_W-1:0] ST_TSEL   = 5'd11;
  localparam logic [STEP_W-1:0] ST_SBGAIN = 5'd12;
  localparam logic [STEP_W-1:0] ST_R0     = 5'd13;
  localparam logic [STEP_W-1:0] ST_R1     = 5'd14;
  localparam logic [STEP_W-1:0] ST_PRE    = 5'd15;
  localparam logic [STEP_W-1:0] ST_SFS    = 5'd16;
  localparam logic [STEP_W-1:0] ST_C1     = 5'd17;
  localparam logic [STEP_W-1:0] ST_BYTE   = 5'd18;
  localparam logic [STEP_W-1:0] ST_DONE   = 5'd19;

  localparam logic [4:0] FID_MAIN_BYTE = 5'd16;

  typedef struct packed {
    logic        kind;
    logic        data_bit;
    logic        stereo;
    logic [10:0] main_data_bytes;
    logic        padding;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic        granule;
    logic        channel;
    logic [10:0] index;
    logic [11:0] value;
    logic        last;
  } out_item_t;

  // Number of bits that make up the field read in a given step.
  function automatic logic [3:0] step_width(input logic [STEP_W-1:0] s,
                                            input logic two_ch);
    logic [3:0] w;
    w = 4'd1;
    case (s)
      ST_MDB:    w = 4'd9;
      ST_PRIV:   w = two_ch ? 4'd3 : 4'd5;
      ST_P23:    w = 4'd12;
      ST_BIGV:   w = 4'd9;
      ST_GGAIN:  w = 4'd8;
      ST_SFC:    w = 4'd4;
      ST_BTYPE:  w = 4'd2;
      ST_TSEL:   w = 4'd5;
      ST_SBGAIN: w = 4'd3;
      ST_R0:     w = 4'd4;
      ST_R1:     w = 4'd3;
      ST_BYTE:   w = 4'd8;
      default:   w = 4'd1;
    endcase
    return w;
  endfunction

  // Field identifier reported for the field completed in a given step.
  function automatic logic [4:0] step_id(input logic [STEP_W-1:0] s);
    logic [4:0] id;
    if (s >= ST_SCFSI && s <= ST_BYTE) begin
      id = s - 5'd2;
    end else begin
      id = 5'd0;
    end
    return id;
  endfunction

endpackage

// ===== sv/mp3sip_parser.sv =====
// Bit-serial side-info parser: field sequencer, bit accumulator and byte packer.
module mp3sip_parser
  import mp3sip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_en,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [11:0]       acc_r, acc_nxt;
  logic              gr_r, gr_nxt;
  logic              ch_r, ch_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic              sw_r, sw_nxt;
  logic              two_ch_r, two_ch_nxt;
  logic [10:0]       bytes_left_r, bytes_left_nxt;
  logic [10:0]       byte_num_r, byte_num_nxt;

  logic [11:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic [11:0] byte_num_inc;
  logic [16:0] n_raw;
  logic [16:0] n_cap;

  assign acc_shift    = {acc_r[10:0], item.data_bit};
  assign cnt_inc      = cnt_r + 4'd1;
  assign byte_num_inc = {1'b0, byte_num_r} + 12'd1;

  always_comb begin
    n_raw = {6'd0, item.main_data_bytes};
    if (item.padding && (item.main_data_bytes != 11'd0)) begin
      n_raw = {6'd0, item.main_data_bytes} - 17'd1;
    end
    n_cap = (n_raw > 17'(MAIN_BYTES_MAX)) ? 17'(MAIN_BYTES_MAX) : n_raw;
  end

  always_comb begin
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    gr_nxt         = gr_r;
    ch_nxt         = ch_r;
    sub_nxt        = sub_r;
    sw_nxt         = sw_r;
    two_ch_nxt     = two_ch_r;
    bytes_left_nxt = bytes_left_r;
    byte_num_nxt   = byte_num_r;
    res_valid      = 1'b0;
    res.field_id   = step_id(step_r);
    res.granule    = 1'b0;
    res.channel    = 1'b0;
    res.index      = 11'd0;
    res.value      = acc_shift;
    res.last       = 1'b0;

    if (item_en) begin
      if (!item.kind) begin
        // A frame start abandons whatever frame was in progress.
        step_nxt       = ST_MDB;
        cnt_nxt        = 4'd0;
        acc_nxt        = 12'd0;
        gr_nxt         = 1'b0;
        ch_nxt         = 1'b0;
        sub_nxt        = 2'd0;
        sw_nxt         = 1'b0;
        two_ch_nxt     = item.stereo;
        bytes_left_nxt = n_cap[10:0];
        byte_num_nxt   = 11'd0;
      end else if (step_r != ST_IDLE && step_r < ST_DONE) begin
        if (cnt_inc < step_width(step_r, two_ch_r)) begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
        end else begin
          acc_nxt   = 12'd0;
          cnt_nxt   = 4'd0;
          res_valid = 1'b1;
          unique case (step_r)
            ST_MDB: begin
              step_nxt = ST_PRIV;
              sub_nxt  = 2'd0;
            end
            ST_PRIV: begin
              res_valid = 1'b0;
              ch_nxt    = 1'b0;
              step_nxt  = ST_SCFSI;
              sub_nxt   = 2'd0;
            end
            ST_SCFSI: begin
              res.channel = ch_r;
              res.index   = {9'd0, sub_r};
              if (sub_r < 2'd3) begin
                sub_nxt = sub_r + 2'd1;
              end else if (two_ch_r && !ch_r) begin
                ch_nxt  = 1'b1;
                sub_nxt = 2'd0;
              end else begin
                gr_nxt   = 1'b0;
                ch_nxt   = 1'b0;
                step_nxt = ST_P23;
                sub_nxt  = 2'd0;
              end
            end
            ST_P23, ST_BIGV, ST_GGAIN, ST_SFC, ST_BTYPE, ST_MIXED, ST_R0, ST_R1,
            ST_PRE, ST_SFS: begin
              res.granule = gr_r;
              res.channel = ch_r;
              sub_nxt     = 2'd0;
              case (step_r)
                ST_MIXED: step_nxt = ST_TSEL;
                ST_R1:    step_nxt = ST_PRE;
                default:  step_nxt = step_r + 5'd1;
              endcase
            end
            ST_WS: begin
              res.granule = gr_r;
              res.channel = ch_r;
              sw_nxt      = acc_shift[0];
              step_nxt    = acc_shift[0] ? ST_BTYPE : ST_TSEL;
              sub_nxt     = 2'd0;
            end
            ST_TSEL: begin
              res.granule = gr_r;
              res.channel = ch_r;
              res.index   = {9'd0, sub_r};
              if ({1'b0, sub_r} + 3'd1 < (sw_r ? 3'd2 : 3'd3)) begin
                sub_nxt = sub_r + 2'd1;
              end else begin
                step_nxt = sw_r ? ST_SBGAIN : ST_R0;
                sub_nxt  = 2'd0;
              end
            end
            ST_SBGAIN: begin
              res.granule = gr_r;
              res.channel = ch_r;
              res.index   = {9'd0, sub_r};
              if (sub_r < 2'd2) begin
                sub_nxt = sub_r + 2'd1;
              end else begin
                step_nxt = ST_PRE;
                sub_nxt  = 2'd0;
              end
            end
            ST_C1: begin
              res.granule = gr_r;
              res.channel = ch_r;
              sub_nxt     = 2'd0;
              if (two_ch_r && !ch_r) begin
                ch_nxt   = 1'b1;
                step_nxt = ST_P23;
              end else if (!gr_r) begin
                gr_nxt   = 1'b1;
                ch_nxt   = 1'b0;
                step_nxt = ST_P23;
              end else if (bytes_left_r != 11'd0) begin
                byte_num_nxt = 11'd0;
                step_nxt     = ST_BYTE;
              end else begin
                res.last = 1'b1;
                step_nxt = ST_DONE;
              end
            end
            ST_BYTE: begin
              res.index    = byte_num_r;
              byte_num_nxt = byte_num_inc[10:0];
              if (byte_num_inc >= {1'b0, bytes_left_r}) begin
                res.last = 1'b1;
                step_nxt = ST_DONE;
                sub_nxt  = 2'd0;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_IDLE;
      cnt_r        <= 4'd0;
      acc_r        <= 12'd0;
      gr_r         <= 1'b0;
      ch_r         <= 1'b0;
      sub_r        <= 2'd0;
      sw_r         <= 1'b0;
      two_ch_r     <= 1'b0;
      bytes_left_r <= 11'd0;
      byte_num_r   <= 11'd0;
    end else begin
      step_r       <= step_nxt;
      cnt_r        <= cnt_nxt;
      acc_r        <= acc_nxt;
      gr_r         <= gr_nxt;
      ch_r         <= ch_nxt;
      sub_r        <= sub_nxt;
      sw_r         <= sw_nxt;
      two_ch_r     <= two_ch_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_num_r   <= byte_num_nxt;
    end
  end

  a_cnt_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 4'd12)
    else $error("bit counter ran past the widest field");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last && item.kind) |=> (step_r == ST_DONE))
    else $error("last word did not close the frame");

  a_byte_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_BYTE) |-> (byte_num_r < bytes_left_r))
    else $error("byte position beyond main data size");

endmodule

// ===== sv/mp3sip_outbuf.sv =====
// Two-word result buffer: output register plus skid register.
module mp3sip_outbuf
  import mp3sip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_v_r, out_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t out_d_r, out_d_nxt;
  out_item_t skid_d_r, skid_d_nxt;
  logic      pop;

  assign pop       = out_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      // Input is held off while the skid word waits, so no push here.
      if (pop) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (out_v_r && !pop) begin
      if (push) begin
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end else begin
      out_v_nxt = push;
      if (push) begin
        out_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held with an empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("word pushed into a full buffer");

endmodule

// ===== sv/mp3_side_info_bit_parser_top.sv =====
// Top level of the MPEG-1 Layer III side-info bit parser.
//
// Input words arrive on in_valid/in_stall/in_data. A frame-start word (kind 0)
// sets the channel mode and main-data size; each data word (kind 1) carries
// one bit of the frame, most significant first. Result words leave on
// out_valid/out_stall/out_data, one per packed main-data byte or completed
// side-info field save the private bits; last is set on the frame's final word.
// Throughput is one input word per cycle while in_stall is low: each bit only
// moves small counters and the 12-bit accumulator between the state registers.
// A result word is registered before it appears on out_data.
// When the receiver stalls, the word on out_data is held and one further
// result is parked in a skid register; in_stall rises only while that skid
// register is occupied, so words that complete no field still flow.
// Synchronous reset empties both result registers and returns the parser to
// idle; data bits seen before any frame start are dropped.
module mp3_side_info_bit_parser_top
  import mp3sip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      item_en;
  logic      res_valid;
  out_item_t res;
  logic      buf_full;

  assign in_stall = buf_full;
  assign item_en  = in_valid && !buf_full;

  mp3sip_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_en   (item_en),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  mp3sip_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
